FILE: design/pn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_pkg: shared types, constants and tables for the perceptron neuron
// widths of the fixed-point formats, activation codes, queue entry and the
// piecewise-linear breakpoint tables of tanh and sigmoid
// ----------------------------------------------------------------------------
package pn_pkg;

  // fixed-point formats
  localparam int DATA_W    = 16;              // q4.12 samples, weights, results
  localparam int FRAC_BITS = 12;
  localparam int PROD_W    = 2 * DATA_W;      // q8.24 product
  localparam int ACC_BITS  = 48;              // q24.24 accumulator
  localparam int SEGMENTS  = 16;              // unit-wide table segments over [-8,8)
  localparam int IDX_W     = $clog2(SEGMENTS + 1);
  localparam int POS_W     = DATA_W + 2;
  localparam int ONE_FX    = 1 << FRAC_BITS;
  localparam int HALF_FX   = ONE_FX >> 1;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b1;

  typedef enum logic [2:0] {
    MODE_RELU      = 3'd0,
    MODE_TANH      = 3'd1,
    MODE_LINEAR    = 3'd2,
    MODE_THRESH    = 3'd3,
    MODE_PIECEWISE = 3'd4,
    MODE_SIGMOID   = 3'd5
  } act_mode_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_BIAS,
    ST_ACT,
    ST_FIN
  } back_state_t;

  // one queued element: full-precision product and end-of-vector mark
  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic                     last;
  } pn_entry_t;

  // tanh breakpoints at x = -8 .. 8, q4.12
  function automatic logic signed [DATA_W-1:0] tanh_point(input logic [IDX_W-1:0] idx);
    logic signed [DATA_W-1:0] p;
    unique case (idx)
      5'd0, 5'd1, 5'd2, 5'd3: p = -16'sd4096;
      5'd4:  p = -16'sd4093;
      5'd5:  p = -16'sd4076;
      5'd6:  p = -16'sd3949;
      5'd7:  p = -16'sd3119;
      5'd8:  p = 16'sd0;
      5'd9:  p = 16'sd3119;
      5'd10: p = 16'sd3949;
      5'd11: p = 16'sd4076;
      5'd12: p = 16'sd4093;
      default: p = 16'sd4096;
    endcase
    return p;
  endfunction

  // sigmoid 1/(1+exp(-0.5x)) breakpoints at x = -8 .. 8, q4.12
  function automatic logic signed [DATA_W-1:0] sigm_point(input logic [IDX_W-1:0] idx);
    logic signed [DATA_W-1:0] p;
    unique case (idx)
      5'd0:  p = 16'sd74;
      5'd1:  p = 16'sd120;
      5'd2:  p = 16'sd194;
      5'd3:  p = 16'sd311;
      5'd4:  p = 16'sd488;
      5'd5:  p = 16'sd747;
      5'd6:  p = 16'sd1102;
      5'd7:  p = 16'sd1546;
      5'd8:  p = 16'sd2048;
      5'd9:  p = 16'sd2550;
      5'd10: p = 16'sd2994;
      5'd11: p = 16'sd3349;
      5'd12: p = 16'sd3608;
      5'd13: p = 16'sd3785;
      5'd14: p = 16'sd3902;
      5'd15: p = 16'sd3976;
      default: p = 16'sd4022;
    endcase
    return p;
  endfunction

  // saturate a sum that grew by one bit back to the accumulator range
  function automatic logic signed [ACC_BITS-1:0] sat_acc(
      input logic signed [ACC_BITS:0] v);
    logic signed [ACC_BITS-1:0] r;
    if (v[ACC_BITS] != v[ACC_BITS-1]) begin
      r = v[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      r = v[ACC_BITS-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/perceptron_neuron.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perceptron_neuron: weighted sum with selectable activation
// q4.12 sample times weight, saturating q24.24 accumulate, bias, floor to
// q4.12, then relu, tanh, linear, threshold, piecewise or sigmoid
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   -----------------------------------------
//  input     in_valid / in_stall     sample_value, weight_value, last_element
//  result    out_valid / out_stall   activated_value, mode_error
//  config    cfg_write               cfg_index, cfg_data (0 bias, 1 mode)
//
//  one element enters per cycle while the product queue has room; each item
//  is registered in the queue, then the back end retires one product a cycle
//  while it is in its run state and the queue holds items; after the last
//  element of a vector the back end steps through bias and round, table lookup
//  and multiply, and final add; short vectors can fill the queue
//  a stalled result holds the back end in its final step; the queue keeps
//  taking items until it is full, then in_stall rises
//  synchronous reset clears the queue, sequencer, accumulator, configuration
//  registers and out_valid
//
module perceptron_neuron #(
  parameter int QUEUE_DEPTH = pn_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pn_pkg::DATA_W-1:0]    sample_value,
  input  logic signed [pn_pkg::DATA_W-1:0]    weight_value,
  input  logic                                last_element,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pn_pkg::DATA_W-1:0]    activated_value,
  output logic                                mode_error,
  // configuration writes
  input  logic                                cfg_write,
  input  logic [pn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pn_pkg::DATA_W-1:0]           cfg_data
);

  // configuration registers
  logic signed [pn_pkg::DATA_W-1:0] bias_reg;
  pn_pkg::act_mode_t                mode_reg;

  // front to queue
  logic              q_push;
  logic              q_full;
  pn_pkg::pn_entry_t q_wr_entry;
  // queue to back
  logic              q_pop;
  logic              q_empty;
  pn_pkg::pn_entry_t q_rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_reg <= '0;
      mode_reg <= pn_pkg::MODE_RELU;
    end else if (cfg_write) begin
      if (cfg_index == pn_pkg::REG_BIAS) begin
        bias_reg <= $signed(cfg_data);
      end
      if (cfg_index == pn_pkg::REG_MODE) begin
        // only the low three bits carry the mode
        mode_reg <= pn_pkg::act_mode_t'(cfg_data[2:0]);
      end
    end
  end

  // takes items and forms products
  pn_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .weight_value (weight_value),
    .last_element (last_element),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_wr_entry)
  );

  // short queue so that input and result stalls stay apart
  pn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  // accumulate, then bias, round and activate on the last element
  pn_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_entry         (q_rd_entry),
    .q_pop           (q_pop),
    .bias_value      (bias_reg),
    .activation_mode (mode_reg),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .activated_value (activated_value),
    .mode_error      (mode_error)
  );

endmodule

FILE: design/pn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_front: input side of the neuron
// takes items while the queue has room and forms the q8.24 product
// ----------------------------------------------------------------------------
module pn_front (
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pn_pkg::DATA_W-1:0]  sample_value,
  input  logic signed [pn_pkg::DATA_W-1:0]  weight_value,
  input  logic                              last_element,
  input  logic                              q_full,
  output logic                              q_push,
  output pn_pkg::pn_entry_t                 q_entry
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // 16x16 signed product, registered by the queue storage
  assign q_entry.prod = sample_value * weight_value;
  assign q_entry.last = last_element;

endmodule

FILE: design/pn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_queue: short fall-through queue of products
// decouples the input handshake from the accumulate and activation sequence
// ----------------------------------------------------------------------------
module pn_queue #(
  parameter int DEPTH = pn_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pn_pkg::pn_entry_t wr_entry,
  input  logic              pop,
  output pn_pkg::pn_entry_t rd_entry,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pn_pkg::pn_entry_t store [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/pn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_back: accumulate and activation sequencer
// saturating accumulate per element; on the last one bias, round, activate
// ----------------------------------------------------------------------------
module pn_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  pn_pkg::pn_entry_t                 q_entry,
  output logic                              q_pop,
  input  logic signed [pn_pkg::DATA_W-1:0]  bias_value,
  input  pn_pkg::act_mode_t                 activation_mode,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pn_pkg::DATA_W-1:0]  activated_value,
  output logic                              mode_error
);

  localparam int DW  = pn_pkg::DATA_W;
  localparam int FB  = pn_pkg::FRAC_BITS;
  localparam int AW  = pn_pkg::ACC_BITS;
  localparam int PW  = pn_pkg::POS_W;
  localparam int IW  = pn_pkg::IDX_W;
  localparam int DFW = DW + 1;
  localparam int TPW = DFW + FB + 1;
  localparam logic signed [DW-1:0] ONE_Q  = DW'(pn_pkg::ONE_FX);
  localparam logic signed [DW-1:0] HALF_Q = DW'(pn_pkg::HALF_FX);
  localparam logic signed [PW-1:0] POS_OFS = PW'((pn_pkg::SEGMENTS / 2) * pn_pkg::ONE_FX);
  localparam logic signed [PW-1:0] POS_END = PW'(pn_pkg::SEGMENTS * pn_pkg::ONE_FX);
  localparam logic [IW-1:0]        IDX_END = IW'(pn_pkg::SEGMENTS);

  pn_pkg::back_state_t state, state_next;
  logic load_out;

  // datapath registers
  logic signed [AW-1:0]  acc;
  logic signed [DW-1:0]  x_sat;
  logic signed [DW-1:0]  base;
  logic signed [TPW-1:0] term_prod;
  logic signed [DW-1:0]  y_simple;
  logic                  use_pwl;
  logic                  err;

  // accumulate
  logic signed [AW:0]    acc_sum;
  // bias and rounding
  logic signed [AW:0]    biased_sum;
  logic signed [AW-1:0]  total;
  logic signed [AW-1:0]  shifted;
  logic                  fits;
  logic signed [DW-1:0]  x_clamped;
  // activation
  logic signed [PW-1:0]  pos;
  logic [IW-1:0]         idx;
  logic [FB-1:0]         frac;
  logic                  sel_sigm;
  logic signed [DW-1:0]  p0;
  logic signed [DW-1:0]  p1;
  logic signed [DW-1:0]  base_d;
  logic signed [DFW-1:0] diff_d;
  logic signed [DW-1:0]  simple_d;
  logic                  err_d;
  logic signed [DW-1:0]  y_fin;

  assign acc_sum    = (AW + 1)'(acc) + (AW + 1)'(q_entry.prod);
  assign biased_sum = (AW + 1)'(acc) + (AW + 1)'($signed({bias_value, {FB{1'b0}}}));
  assign total      = pn_pkg::sat_acc(biased_sum);
  assign shifted    = total >>> FB;
  assign fits       = (&shifted[AW-1:DW-1]) || !(|shifted[AW-1:DW-1]);
  assign x_clamped  = fits ? shifted[DW-1:0]
                           : (shifted[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

  // table lookup position, x + 8.0
  assign pos      = PW'(x_sat) + POS_OFS;
  assign idx      = pos[FB +: IW];
  assign frac     = pos[FB-1:0];
  assign sel_sigm = (activation_mode == pn_pkg::MODE_SIGMOID);

  always_comb begin
    p0 = sel_sigm ? pn_pkg::sigm_point(idx) : pn_pkg::tanh_point(idx);
    p1 = sel_sigm ? pn_pkg::sigm_point(idx + 1'b1) : pn_pkg::tanh_point(idx + 1'b1);
    if (pos[PW-1]) begin
      // below the table span
      base_d = sel_sigm ? pn_pkg::sigm_point('0) : pn_pkg::tanh_point('0);
      diff_d = '0;
    end else if (pos >= POS_END) begin
      // at or above the table span
      base_d = sel_sigm ? pn_pkg::sigm_point(IDX_END) : pn_pkg::tanh_point(IDX_END);
      diff_d = '0;
    end else begin
      base_d = p0;
      diff_d = DFW'(p1) - DFW'(p0);
    end
  end

  always_comb begin
    err_d = 1'b0;
    unique case (activation_mode)
      pn_pkg::MODE_RELU:      simple_d = x_sat[DW-1] ? '0 : x_sat;
      pn_pkg::MODE_LINEAR:    simple_d = x_sat;
      pn_pkg::MODE_THRESH:    simple_d = x_sat[DW-1] ? '0 : ONE_Q;
      pn_pkg::MODE_PIECEWISE: begin
        if (x_sat >= HALF_Q) begin
          simple_d = ONE_Q;
        end else if (x_sat <= -HALF_Q) begin
          simple_d = '0;
        end else begin
          simple_d = x_sat;
        end
      end
      pn_pkg::MODE_TANH, pn_pkg::MODE_SIGMOID: simple_d = x_sat;
      default: begin
        simple_d = x_sat;
        err_d    = 1'b1;
      end
    endcase
  end

  assign y_fin = use_pwl ? DW'(base + DW'(term_prod >>> FB)) : y_simple;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pn_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      pn_pkg::ST_RUN: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_entry.last) begin
            state_next = pn_pkg::ST_BIAS;
          end
        end
      end
      pn_pkg::ST_BIAS: state_next = pn_pkg::ST_ACT;
      pn_pkg::ST_ACT:  state_next = pn_pkg::ST_FIN;
      pn_pkg::ST_FIN: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = pn_pkg::ST_RUN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (q_pop) begin
      acc <= pn_pkg::sat_acc(acc_sum);
    end else if (state == pn_pkg::ST_BIAS) begin
      acc <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pn_pkg::ST_BIAS) begin
      x_sat <= x_clamped;
    end
    if (state == pn_pkg::ST_ACT) begin
      base      <= base_d;
      term_prod <= diff_d * $signed({1'b0, frac});
      y_simple  <= simple_d;
      use_pwl   <= (activation_mode == pn_pkg::MODE_TANH) || sel_sigm;
      err       <= err_d;
    end
    if (load_out) begin
      activated_value <= y_fin;
      mode_error      <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: design/pn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_checker: port-level checks of the perceptron neuron
// follows the mode register from the config port and checks results against it
// ----------------------------------------------------------------------------
module pn_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [pn_pkg::DATA_W-1:0] activated_value,
  input logic                             mode_error,
  input logic                             cfg_write,
  input logic [pn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [pn_pkg::DATA_W-1:0]        cfg_data
);

  logic [2:0] mode_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_seen <= pn_pkg::MODE_RELU;
    end else if (cfg_write && cfg_index == pn_pkg::REG_MODE) begin
      mode_seen <= cfg_data[2:0];
    end
  end

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid && $stable(activated_value) && $stable(mode_error))
    else $error("stalled result changed");

  // error flag follows the configured mode
  a_err_flag: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> mode_error == (mode_seen == 3'd6 || mode_seen == 3'd7))
    else $error("mode_error does not match mode");

  // relu never gives a negative value
  a_relu: assert property (@(posedge clk) disable iff (rst)
      out_valid && mode_seen == pn_pkg::MODE_RELU |-> !activated_value[pn_pkg::DATA_W-1])
    else $error("negative relu result");

  // threshold gives zero or one
  a_thresh: assert property (@(posedge clk) disable iff (rst)
      out_valid && mode_seen == pn_pkg::MODE_THRESH |->
        activated_value == '0 || activated_value == pn_pkg::DATA_W'(pn_pkg::ONE_FX))
    else $error("threshold result not zero or one");

endmodule

bind perceptron_neuron pn_checker u_pn_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .activated_value (activated_value),
  .mode_error      (mode_error),
  .cfg_write       (cfg_write),
  .cfg_index       (cfg_index),
  .cfg_data        (cfg_data)
);
